// ===== rtl/ssfs_pkg.sv =====
package ssfs_pkg;

   localparam int FRAME_BITS  = 13;
   localparam int PERIOD_BITS = 14;
   localparam int CSR_BITS    = 3;

   // ping-pong with a single frame counts through every frame code
   localparam logic [PERIOD_BITS-1:0] SOLO_PERIOD = PERIOD_BITS'(1 << FRAME_BITS);

   localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = FRAME_BITS'(32);
   localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = FRAME_BITS'(32);
   localparam logic [FRAME_BITS-1:0] SHEET_WIDTH_RESET  = FRAME_BITS'(256);
   localparam logic [FRAME_BITS-1:0] SHEET_HEIGHT_RESET = FRAME_BITS'(256);
   localparam logic [FRAME_BITS-1:0] FRAME_COUNT_RESET  = FRAME_BITS'(8);
   localparam int                    TIME_PER_FRAME_RESET = 100000;
   localparam int                    TIME_RESET_BITS      = 17;

   typedef logic [FRAME_BITS-1:0] frame_type;

   typedef enum logic [CSR_BITS-1:0] {
      REG_FRAME_WIDTH     = 3'd0,
      REG_FRAME_HEIGHT    = 3'd1,
      REG_SHEET_WIDTH     = 3'd2,
      REG_SHEET_HEIGHT    = 3'd3,
      REG_FRAME_COUNT     = 3'd4,
      REG_TIME_PER_FRAME  = 3'd5,
      REG_REPEAT_ENABLE   = 3'd6,
      REG_PINGPONG_ENABLE = 3'd7
   } csr_index_type;

endpackage

// ===== rtl/sprite_sheet_frame_sequencer.sv =====
// Sprite sheet frame sequencer: each request beat is a time tick or a restart, and each
// produces exactly one response beat with the frame rectangle origin, frame index,
// direction and finished flag. A restart goes straight to the done state. A one-shot tick
// steps frames while the elapsed time covers time_per_frame and frames remain. A looped
// tick (repeat or ping-pong) first divides the elapsed time by time_per_frame in a shared
// restoring divider, then takes the frame steps; the same divider folds a long run of
// steps down to under two animation periods (once per tick) and fixes up a frame index
// left beyond frame_count. Step count per tick is bounded by about 8192 plus two
// periods. The request side is ready only between items; a finished response waits in
// its output register while the next request is accepted.
module sprite_sheet_frame_sequencer #(
   parameter int COORD_BITS = 13,
   parameter int TIME_BITS  = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_mode,
   input  logic [TIME_BITS-1:0]                   req_delta_time,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [COORD_BITS-1:0]           rsp_rect_left,
   output logic signed [COORD_BITS-1:0]           rsp_rect_top,
   output logic [ssfs_pkg::FRAME_BITS-1:0]        rsp_frame_index,
   output logic                                   rsp_backwards,
   output logic                                   rsp_finished,
   input  logic                                   csr_write_en,
   input  logic [ssfs_pkg::CSR_BITS-1:0]          csr_index,
   input  logic [TIME_BITS-1:0]                   csr_wdata
);

   localparam int FB        = ssfs_pkg::FRAME_BITS;
   localparam int PB        = ssfs_pkg::PERIOD_BITS;
   localparam int ELAPSED_W = TIME_BITS + 1;
   localparam int DIV_W     = ELAPSED_W;
   localparam int CNT_W     = $clog2(DIV_W + 1);
   localparam int TPF_W     = (TIME_BITS > ssfs_pkg::TIME_RESET_BITS) ?
                              TIME_BITS : ssfs_pkg::TIME_RESET_BITS;
   localparam int CALC_W    = ((COORD_BITS > FB) ? COORD_BITS : FB) + 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_TIME,
      ST_LOOP,
      ST_DIV_COUNT,
      ST_DIV_FRAME,
      ST_ONESHOT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [FB-1:0]    frame_width_ff, frame_width_in;
   logic [FB-1:0]    frame_height_ff, frame_height_in;
   logic [FB-1:0]    sheet_width_ff, sheet_width_in;
   logic [FB-1:0]    sheet_height_ff, sheet_height_in;
   logic [FB-1:0]    frame_count_ff, frame_count_in;
   logic [TPF_W-1:0] tpf_ff, tpf_in;
   logic             repeat_ff, repeat_in;
   logic             pingpong_ff, pingpong_in;

   // animation state
   logic [ELAPSED_W-1:0]         elapsed_ff, elapsed_in;
   logic [FB-1:0]                frame_ff, frame_in;
   logic                         rev_ff, rev_in;
   logic signed [COORD_BITS-1:0] rect_x_ff, rect_x_in;
   logic signed [COORD_BITS-1:0] rect_y_ff, rect_y_in;

   // loop control and shared divider
   logic [DIV_W-1:0] steps_ff, steps_in;
   logic             reduced_ff, reduced_in;
   logic [DIV_W-1:0] div_quo_ff, div_quo_in;
   logic [DIV_W-1:0] div_rem_ff, div_rem_in;
   logic [DIV_W-1:0] div_den_ff, div_den_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] rsp_left_ff, rsp_left_in;
   logic signed [COORD_BITS-1:0] rsp_top_ff, rsp_top_in;
   logic [FB-1:0]                rsp_frame_ff, rsp_frame_in;
   logic                         rsp_back_ff, rsp_back_in;
   logic                         rsp_fin_ff, rsp_fin_in;

   // derived configuration
   logic [FB-1:0]    fc_eff;
   logic [FB-1:0]    last_frame;
   logic [TPF_W-1:0] tpf_eff;
   logic             looped;
   logic [PB-1:0]    period;

   // divider datapath
   logic [DIV_W:0]   div_shift;
   logic [DIV_W:0]   div_sub;
   logic             div_ge;
   logic [DIV_W-1:0] div_rem_fin;
   logic [DIV_W-1:0] div_quo_fin;
   logic             div_last;

   logic [ELAPSED_W:0]   elapsed_sum;
   logic [ELAPSED_W-1:0] elapsed_sat;

   // step datapath
   logic signed [CALC_W-1:0]     x_ext, y_ext, w_ext, h_ext, sw_ext, sh_ext;
   logic signed [CALC_W-1:0]     fwd_l, rev_l, corner_x, corner_y, y_down, y_up;
   logic signed [COORD_BITS-1:0] mv_x, mv_y;
   logic [FB:0]                  frame_inc;
   logic                         rep_needs_div;
   logic [FB-1:0]                rep_next;
   logic [FB-1:0]                step_frame;
   logic                         step_rev;
   logic                         pp_rev;
   logic signed [COORD_BITS-1:0] step_x, step_y;

   assign fc_eff     = (frame_count_ff == '0) ? FB'(1) : frame_count_ff;
   assign last_frame = fc_eff - FB'(1);
   assign tpf_eff    = (tpf_ff == '0) ? TPF_W'(1) : tpf_ff;
   assign looped     = repeat_ff | pingpong_ff;

   always_comb begin
      if (pingpong_ff) begin
         period = (fc_eff != FB'(1)) ? {last_frame, 1'b0} : ssfs_pkg::SOLO_PERIOD;
      end else begin
         period = PB'(fc_eff);
      end
   end

   assign div_shift   = {div_rem_ff, div_quo_ff[DIV_W-1]};
   assign div_ge      = div_shift >= {1'b0, div_den_ff};
   assign div_sub     = div_shift - {1'b0, div_den_ff};
   assign div_rem_fin = div_ge ? div_sub[DIV_W-1:0] : div_shift[DIV_W-1:0];
   assign div_quo_fin = {div_quo_ff[DIV_W-2:0], div_ge};
   assign div_last    = div_cnt_ff == CNT_W'(1);

   assign elapsed_sum = {1'b0, elapsed_ff} + (ELAPSED_W+1)'(req_delta_time);
   assign elapsed_sat = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];

   // rectangle move, row-end tests on the unwrapped sums
   assign x_ext    = CALC_W'(rect_x_ff);
   assign y_ext    = CALC_W'(rect_y_ff);
   assign w_ext    = signed'(CALC_W'(frame_width_ff));
   assign h_ext    = signed'(CALC_W'(frame_height_ff));
   assign sw_ext   = signed'(CALC_W'(sheet_width_ff));
   assign sh_ext   = signed'(CALC_W'(sheet_height_ff));
   assign fwd_l    = x_ext + w_ext;
   assign rev_l    = x_ext - w_ext;
   assign corner_x = sw_ext - w_ext;
   assign corner_y = sh_ext - h_ext;
   assign y_down   = y_ext + h_ext;
   assign y_up     = y_ext - h_ext;

   always_comb begin
      if (!rev_ff) begin
         if ((fwd_l + w_ext) > sw_ext) begin
            mv_x = '0;
            mv_y = y_down[COORD_BITS-1:0];
         end else begin
            mv_x = fwd_l[COORD_BITS-1:0];
            mv_y = rect_y_ff;
         end
      end else begin
         if (rev_l[CALC_W-1]) begin
            mv_x = corner_x[COORD_BITS-1:0];
            mv_y = y_up[COORD_BITS-1:0];
         end else begin
            mv_x = rev_l[COORD_BITS-1:0];
            mv_y = rect_y_ff;
         end
      end
   end

   assign frame_inc     = {1'b0, frame_ff} + (FB+1)'(1);
   assign rep_needs_div = frame_inc > {1'b0, fc_eff};

   always_comb begin
      if (state_ff == ST_DIV_FRAME) begin
         rep_next = div_rem_fin[FB-1:0];
      end else if (frame_inc == {1'b0, fc_eff}) begin
         rep_next = '0;
      end else begin
         rep_next = frame_inc[FB-1:0];
      end
   end

   always_comb begin
      step_x     = mv_x;
      step_y     = mv_y;
      step_rev   = rev_ff;
      step_frame = frame_inc[FB-1:0];
      pp_rev     = (frame_ff == last_frame) ? 1'b1 : rev_ff;
      if (pingpong_ff) begin
         if (frame_ff == '0) begin
            pp_rev = 1'b0;
            step_x = '0;
            step_y = '0;
         end
         if (frame_ff == last_frame) begin
            step_x = corner_x[COORD_BITS-1:0];
            step_y = corner_y[COORD_BITS-1:0];
         end
         step_rev   = pp_rev;
         step_frame = pp_rev ? (frame_ff - FB'(1)) : frame_inc[FB-1:0];
      end else if (repeat_ff) begin
         step_frame = rep_next;
         if (rep_next == '0) begin
            step_x = '0;
            step_y = '0;
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      sheet_width_in  = sheet_width_ff;
      sheet_height_in = sheet_height_ff;
      frame_count_in  = frame_count_ff;
      tpf_in          = tpf_ff;
      repeat_in       = repeat_ff;
      pingpong_in     = pingpong_ff;
      elapsed_in      = elapsed_ff;
      frame_in        = frame_ff;
      rev_in          = rev_ff;
      rect_x_in       = rect_x_ff;
      rect_y_in       = rect_y_ff;
      steps_in        = steps_ff;
      reduced_in      = reduced_ff;
      div_quo_in      = div_quo_fin;
      div_rem_in      = div_rem_fin;
      div_den_in      = div_den_ff;
      div_cnt_in      = div_cnt_ff - CNT_W'(1);
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_left_in     = rsp_left_ff;
      rsp_top_in      = rsp_top_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_back_in     = rsp_back_ff;
      rsp_fin_in      = rsp_fin_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode) begin
                  frame_in   = '0;
                  rev_in     = 1'b0;
                  elapsed_in = '0;
                  rect_x_in  = '0;
                  rect_y_in  = '0;
                  state_in   = ST_DONE;
               end else begin
                  elapsed_in = elapsed_sat;
                  if (frame_ff == '0) begin
                     rect_x_in = '0;
                     rect_y_in = '0;
                  end
                  if (looped) begin
                     div_quo_in = elapsed_sat;
                     div_rem_in = '0;
                     div_den_in = DIV_W'(tpf_eff);
                     div_cnt_in = CNT_W'(DIV_W);
                     reduced_in = 1'b0;
                     state_in   = ST_DIV_TIME;
                  end else begin
                     state_in = ST_ONESHOT;
                  end
               end
            end
         end
         ST_DIV_TIME: begin
            if (div_last) begin
               steps_in   = div_quo_fin;
               elapsed_in = div_rem_fin;
               state_in   = ST_LOOP;
            end
         end
         ST_LOOP: begin
            priority if (steps_ff == '0) begin
               state_in = ST_DONE;
            end else if (!reduced_ff && (frame_ff == '0) &&
                         (steps_ff >= DIV_W'({period, 1'b0}))) begin
               // fold a long run into one period plus the remainder
               div_quo_in = steps_ff;
               div_rem_in = '0;
               div_den_in = DIV_W'(period);
               div_cnt_in = CNT_W'(DIV_W);
               state_in   = ST_DIV_COUNT;
            end else if (!pingpong_ff && rep_needs_div) begin
               // frame left beyond the count, wrap it by a true modulo
               div_quo_in = DIV_W'(frame_inc);
               div_rem_in = '0;
               div_den_in = DIV_W'(fc_eff);
               div_cnt_in = CNT_W'(DIV_W);
               state_in   = ST_DIV_FRAME;
            end else begin
               rect_x_in = step_x;
               rect_y_in = step_y;
               frame_in  = step_frame;
               rev_in    = step_rev;
               steps_in  = steps_ff - DIV_W'(1);
            end
         end
         ST_DIV_COUNT: begin
            if (div_last) begin
               steps_in   = DIV_W'(period) + div_rem_fin;
               reduced_in = 1'b1;
               state_in   = ST_LOOP;
            end
         end
         ST_DIV_FRAME: begin
            if (div_last) begin
               rect_x_in = step_x;
               rect_y_in = step_y;
               frame_in  = step_frame;
               rev_in    = step_rev;
               steps_in  = steps_ff - DIV_W'(1);
               state_in  = ST_LOOP;
            end
         end
         ST_ONESHOT: begin
            if ((elapsed_ff >= ELAPSED_W'(tpf_eff)) && (frame_ff < fc_eff)) begin
               elapsed_in = elapsed_ff - ELAPSED_W'(tpf_eff);
               rect_x_in  = step_x;
               rect_y_in  = step_y;
               frame_in   = step_frame;
               rev_in     = step_rev;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = rect_x_ff;
               rsp_top_in   = rect_y_ff;
               rsp_frame_in = frame_ff;
               rsp_back_in  = rev_ff;
               rsp_fin_in   = !looped && (frame_ff >= fc_eff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_en) begin
         unique case (ssfs_pkg::csr_index_type'(csr_index))
            ssfs_pkg::REG_FRAME_WIDTH:    frame_width_in  = csr_wdata[FB-1:0];
            ssfs_pkg::REG_FRAME_HEIGHT:   frame_height_in = csr_wdata[FB-1:0];
            ssfs_pkg::REG_SHEET_WIDTH:    sheet_width_in  = csr_wdata[FB-1:0];
            ssfs_pkg::REG_SHEET_HEIGHT:   sheet_height_in = csr_wdata[FB-1:0];
            ssfs_pkg::REG_FRAME_COUNT:    frame_count_in  = csr_wdata[FB-1:0];
            ssfs_pkg::REG_TIME_PER_FRAME: tpf_in          = TPF_W'(csr_wdata);
            ssfs_pkg::REG_REPEAT_ENABLE:  repeat_in       = csr_wdata[0];
            ssfs_pkg::REG_PINGPONG_ENABLE: begin
               pingpong_in = csr_wdata[0];
               if (!csr_wdata[0]) begin
                  rev_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_width_ff  <= ssfs_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= ssfs_pkg::FRAME_HEIGHT_RESET;
         sheet_width_ff  <= ssfs_pkg::SHEET_WIDTH_RESET;
         sheet_height_ff <= ssfs_pkg::SHEET_HEIGHT_RESET;
         frame_count_ff  <= ssfs_pkg::FRAME_COUNT_RESET;
         tpf_ff          <= TPF_W'(ssfs_pkg::TIME_PER_FRAME_RESET);
         repeat_ff       <= 1'b0;
         pingpong_ff     <= 1'b0;
         elapsed_ff      <= '0;
         frame_ff        <= '0;
         rev_ff          <= 1'b0;
         rect_x_ff       <= '0;
         rect_y_ff       <= '0;
         steps_ff        <= '0;
         reduced_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         sheet_width_ff  <= sheet_width_in;
         sheet_height_ff <= sheet_height_in;
         frame_count_ff  <= frame_count_in;
         tpf_ff          <= tpf_in;
         repeat_ff       <= repeat_in;
         pingpong_ff     <= pingpong_in;
         elapsed_ff      <= elapsed_in;
         frame_ff        <= frame_in;
         rev_ff          <= rev_in;
         rect_x_ff       <= rect_x_in;
         rect_y_ff       <= rect_y_in;
         steps_ff        <= steps_in;
         reduced_ff      <= reduced_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      div_quo_ff   <= div_quo_in;
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_top_ff   <= rsp_top_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_back_ff  <= rsp_back_in;
      rsp_fin_ff   <= rsp_fin_in;
   end

   assign req_ready       = state_ff == ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rect_left   = rsp_left_ff;
   assign rsp_rect_top    = rsp_top_ff;
   assign rsp_frame_index = rsp_frame_ff;
   assign rsp_backwards   = rsp_back_ff;
   assign rsp_finished    = rsp_fin_ff;

endmodule

// ===== rtl/ssfs_checker.sv =====
module ssfs_checker #(
   parameter int COORD_BITS = 13
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_mode,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [COORD_BITS-1:0]    rsp_rect_left,
   input logic signed [COORD_BITS-1:0]    rsp_rect_top,
   input logic [ssfs_pkg::FRAME_BITS-1:0] rsp_frame_index,
   input logic                            rsp_backwards,
   input logic                            rsp_finished
);

   // a stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rect_left) &&
         $stable(rsp_rect_top) && $stable(rsp_frame_index) &&
         $stable(rsp_backwards) && $stable(rsp_finished))
      else $error("response beat changed while stalled");

   // the request side is not ready in the cycle after it accepts a beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request side ready right after a beat");

   // one-shot done never plays in reverse
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> !rsp_backwards)
      else $error("finished and backwards together");

   // restart with an empty response register shows the origin once it passes the done state into the response register
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode && !rsp_valid |-> ##2
         (rsp_valid && rsp_rect_left == '0 && rsp_rect_top == '0 &&
          rsp_frame_index == '0 && !rsp_backwards))
      else $error("restart response not at origin");

endmodule

bind sprite_sheet_frame_sequencer ssfs_checker #(
   .COORD_BITS(COORD_BITS)
) u_ssfs_checker (.*);

// ===== dv/tb_sprite_sheet_frame_sequencer.sv =====
`timescale 1ns / 1ps

module tb_sprite_sheet_frame_sequencer;
   import ssfs_pkg::*;

   localparam int                COORD_W     = 13;
   localparam int                TICK_W      = 24;
   localparam longint            ELAPSED_CAP = (longint'(1) << (TICK_W + 1)) - 1;
   localparam int                FRAME_SPAN  = 1 << FRAME_BITS;
   localparam logic [TICK_W-1:0] TICK_MAX    = '1;
   localparam int                CYCLE_LIMIT = 4_000_000;
   localparam int                PRINT_LIMIT = 100;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      frame_type          frame;
      logic               back;
      logic               done;
   } frame_view_t;

   class frame_ledger;
      int          frame_w, frame_h, sheet_w, sheet_h, frame_total;
      longint      tick_per_frame;
      bit          looping, bouncing;
      longint      elapsed;
      int          frame_no;
      bit          reversed;
      int          rect_x, rect_y;
      frame_view_t expected_frames[$];
      int          errors;

      function new();
         frame_w        = int'(FRAME_WIDTH_RESET);
         frame_h        = int'(FRAME_HEIGHT_RESET);
         sheet_w        = int'(SHEET_WIDTH_RESET);
         sheet_h        = int'(SHEET_HEIGHT_RESET);
         frame_total    = int'(FRAME_COUNT_RESET);
         tick_per_frame = TIME_PER_FRAME_RESET;
         looping        = 1'b0;
         bouncing       = 1'b0;
         elapsed        = 0;
         frame_no       = 0;
         reversed       = 1'b0;
         rect_x         = 0;
         rect_y         = 0;
         errors         = 0;
      endfunction

      function int frames_eff();
         return (frame_total == 0) ? 1 : frame_total;
      endfunction

      function longint tick_eff();
         return (tick_per_frame == 0) ? 1 : tick_per_frame;
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction

      function int wrap_coord(int v);
         logic signed [COORD_W-1:0] s;
         s = v[COORD_W-1:0];
         return int'(s);
      endfunction

      function void write_reg(csr_index_type idx, logic [TICK_W-1:0] v);
         case (idx)
            REG_FRAME_WIDTH:    frame_w = int'(v[FRAME_BITS-1:0]);
            REG_FRAME_HEIGHT:   frame_h = int'(v[FRAME_BITS-1:0]);
            REG_SHEET_WIDTH:    sheet_w = int'(v[FRAME_BITS-1:0]);
            REG_SHEET_HEIGHT:   sheet_h = int'(v[FRAME_BITS-1:0]);
            REG_FRAME_COUNT:    frame_total = int'(v[FRAME_BITS-1:0]);
            REG_TIME_PER_FRAME: tick_per_frame = longint'(v);
            REG_REPEAT_ENABLE:  looping = v[0];
            REG_PINGPONG_ENABLE: begin
               bouncing = v[0];
               if (!v[0]) reversed = 1'b0;
            end
            default: ;
         endcase
      endfunction

      // row-end tests use the unwrapped sum
      function void move_rect();
         int l;
         if (!reversed) begin
            l = rect_x + frame_w;
            if (l + frame_w > sheet_w) begin
               rect_x = 0;
               rect_y = wrap_coord(rect_y + frame_h);
            end else begin
               rect_x = wrap_coord(l);
            end
         end else begin
            l = rect_x - frame_w;
            if (l < 0) begin
               rect_x = wrap_coord(sheet_w - frame_w);
               rect_y = wrap_coord(rect_y - frame_h);
            end else begin
               rect_x = wrap_coord(l);
            end
         end
      endfunction

      function void take_step();
         int fc;
         int last;
         fc = frames_eff();
         last = fc - 1;
         move_rect();
         if (bouncing) begin
            if (frame_no == last) reversed = 1'b1;
            if (frame_no == 0) begin
               reversed = 1'b0;
               rect_x = 0;
               rect_y = 0;
            end
            if (frame_no == last) begin
               rect_x = wrap_coord(sheet_w - frame_w);
               rect_y = wrap_coord(sheet_h - frame_h);
            end
            if (reversed) frame_no = (frame_no - 1) & (FRAME_SPAN - 1);
            else frame_no = (frame_no + 1) & (FRAME_SPAN - 1);
         end else if (looping) begin
            frame_no = (frame_no + 1) % fc;
            if (frame_no == 0) begin
               rect_x = 0;
               rect_y = 0;
            end
         end else begin
            frame_no = (frame_no + 1) & (FRAME_SPAN - 1);
         end
      endfunction

      function void note_tick(logic restart, logic [TICK_W-1:0] delta);
         frame_view_t r;
         bit          looped;
         bit          folded;
         int          fc;
         longint      t, n, period;
         looped = looping | bouncing;
         fc = frames_eff();
         t = tick_eff();
         if (restart) begin
            frame_no = 0;
            reversed = 1'b0;
            elapsed = 0;
            rect_x = 0;
            rect_y = 0;
         end else begin
            elapsed += longint'(delta);
            if (elapsed > ELAPSED_CAP) elapsed = ELAPSED_CAP;
            if (frame_no == 0) begin
               rect_x = 0;
               rect_y = 0;
            end
            if (looped) begin
               n = elapsed / t;
               elapsed = elapsed % t;
               if (bouncing) period = (fc >= 2) ? 2 * (fc - 1) : FRAME_SPAN;
               else period = fc;
               folded = 1'b0;
               // long runs fold to under two periods once frame zero comes by
               while (n > 0) begin
                  if (!folded && frame_no == 0 && n >= 2 * period) begin
                     n = period + n % period;
                     folded = 1'b1;
                  end
                  take_step();
                  n--;
               end
            end else begin
               while (elapsed >= t && frame_no < fc) begin
                  elapsed -= t;
                  take_step();
               end
            end
         end
         r.left  = rect_x[COORD_W-1:0];
         r.top   = rect_y[COORD_W-1:0];
         r.frame = frame_no[FRAME_BITS-1:0];
         r.back  = reversed;
         r.done  = !looped && frame_no >= fc;
         expected_frames.push_back(r);
      endfunction

      task report(string msg);
         if (errors < PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
         errors++;
      endtask

      task check_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
      endtask

      task check_beat(frame_view_t got);
         frame_view_t want;
         if (expected_frames.size() == 0) begin
            report($sformatf("response beat with nothing pending, frame %0d", got.frame));
            return;
         end
         want = expected_frames.pop_front();
         check_field("rect_left", 16'(got.left), 16'(want.left));
         check_field("rect_top", 16'(got.top), 16'(want.top));
         check_field("frame_index", 16'(got.frame), 16'(want.frame));
         check_field("backwards", 16'(got.back), 16'(want.back));
         check_field("finished", 16'(got.done), 16'(want.done));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_mode = 1'b0;
   logic [TICK_W-1:0]         req_delta_time = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [COORD_W-1:0] rsp_rect_left;
   logic signed [COORD_W-1:0] rsp_rect_top;
   logic [FRAME_BITS-1:0]     rsp_frame_index;
   logic                      rsp_backwards;
   logic                      rsp_finished;
   logic                      csr_write_en = 1'b0;
   csr_index_type             csr_index = REG_FRAME_WIDTH;
   logic [TICK_W-1:0]         csr_wdata = '0;

   frame_ledger ledger;
   bit          calm = 1'b0;
   int          stall_left = 0;
   int          cycle_count = 0;

   sprite_sheet_frame_sequencer #(
      .COORD_BITS(COORD_W),
      .TIME_BITS (TICK_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_delta_time (req_delta_time),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rect_left  (rsp_rect_left),
      .rsp_rect_top   (rsp_rect_top),
      .rsp_frame_index(rsp_frame_index),
      .rsp_backwards  (rsp_backwards),
      .rsp_finished   (rsp_finished),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // deltas scaled to the frame period so that runs walk through frames
   function automatic logic [TICK_W-1:0] pick_delta();
      longint step, d;
      int     span, r;
      step = ledger.tick_eff();
      span = ledger.frames_eff();
      r = $urandom_range(0, 99);
      if (r < 8) d = 0;
      else if (r < 40) d = $urandom_range(0, int'(step - 1));
      else if (r < 75) d = step * $urandom_range(1, 3);
      else if (r < 88) d = step * $urandom_range(1, 2 * span + 2);
      else if (r < 96) d = longint'(TICK_W'($urandom()));
      else d = TICK_MAX;
      return (d > TICK_MAX) ? TICK_MAX : TICK_W'(d);
   endfunction

   task automatic send_beat(input logic restart, input logic [TICK_W-1:0] delta);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= restart;
      req_delta_time <= delta;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.note_tick(restart, delta);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [TICK_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      ledger.write_reg(idx, val);
   endtask

   task automatic configure(input logic [TICK_W-1:0] fw, fh, sw, sh, fc, tpf, rep, pp);
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      put_reg(REG_FRAME_WIDTH, fw);
      put_reg(REG_FRAME_HEIGHT, fh);
      put_reg(REG_SHEET_WIDTH, sw);
      put_reg(REG_SHEET_HEIGHT, sh);
      put_reg(REG_FRAME_COUNT, fc);
      put_reg(REG_TIME_PER_FRAME, tpf);
      put_reg(REG_REPEAT_ENABLE, rep);
      put_reg(REG_PINGPONG_ENABLE, pp);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_ticks(input int count);
      calm = ($urandom_range(0, 3) == 0);
      repeat (count) begin
         if ($urandom_range(0, 19) == 0) send_beat(1'b1, TICK_W'($urandom()));
         else send_beat(1'b0, pick_delta());
      end
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            ledger.check_beat(frame_view_t'{rsp_rect_left, rsp_rect_top, rsp_frame_index,
                                            rsp_backwards, rsp_finished});
         if (stall_left > 0 && !calm) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sprite_sheet_frame_sequencer verification failed");
         $finish;
      end
   end

   initial begin
      ledger = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // one-shot at reset settings: partial steps, restart, finish, accumulator saturation
      send_beat(1'b0, 0);
      send_beat(1'b0, 100000);
      send_beat(1'b0, 250000);
      send_beat(1'b1, 24'hABCDEF);
      send_beat(1'b0, TICK_MAX);
      send_beat(1'b0, TICK_MAX);
      send_beat(1'b0, TICK_MAX);
      send_beat(1'b0, 1);

      // zero frame count and zero period, looping with the frame left past the count
      configure(5, 7, 30, 20, 0, 0, 1, 0);
      send_beat(1'b0, 5);
      send_beat(1'b0, TICK_MAX);

      // single-frame ping-pong counts through every frame code
      configure(16, 16, 64, 64, 1, 1, 0, 1);
      send_beat(1'b0, 3);
      send_beat(1'b0, TICK_MAX);
      send_beat(1'b1, 0);

      // coordinates wrap past the signed range
      configure(2500, 3000, 8191, 1, 30, 10, 0, 0);
      send_beat(1'b0, 10);
      send_beat(1'b0, 20);
      send_beat(1'b0, 40);

      // ping-pong turns, then the count shrinks under the current frame
      configure(16, 8, 64, 40, 6, 1, 0, 1);
      send_beat(1'b0, 2);
      send_beat(1'b1, 0);
      send_beat(1'b0, 4);
      send_beat(1'b0, 3);
      configure(16, 8, 64, 40, 2, 1, 0, 1);
      send_beat(1'b0, 1);
      send_beat(1'b0, 5);
      configure(16, 8, 64, 40, 3, 1, 1, 0);
      send_beat(1'b0, 1);
      send_beat(1'b0, 4);

      configure(32, 32, 256, 256, 8, 1000, 0, 0);
      run_ticks(120);
      configure(30, 20, 100, 60, 5, 7, 1, 0);
      run_ticks(120);
      configure(24, 16, 96, 64, 6, 3, 0, 1);
      run_ticks(120);
      configure(16, 16, 64, 64, 1, 100000, 0, 1);
      run_ticks(30);
      configure(7, 5, 40, 30, 0, 0, 1, 0);
      run_ticks(30);

      for (int p = 0; p < 7; p++) begin
         configure(TICK_W'($urandom_range(1, 48)), TICK_W'($urandom_range(1, 48)),
                   TICK_W'($urandom_range(1, 320)), TICK_W'($urandom_range(1, 320)),
                   TICK_W'($urandom_range(1, 12)),
                   ($urandom_range(0, 7) == 0) ? TICK_W'($urandom_range(1, TICK_MAX))
                                               : TICK_W'($urandom_range(1, 3000)),
                   TICK_W'($urandom_range(0, 1)), TICK_W'($urandom_range(0, 1)));
         run_ticks(110);
      end

      // register extremes; the slow ones get few beats
      configure(4096, 4096, 4096, 4096, 4096, TICK_MAX, 0, 1);
      run_ticks(12);
      configure(1, 1, 1, 1, 1, 1, 1, 0);
      run_ticks(30);
      configure(4096, 1, 4096, 4096, 4096, 1, 1, 0);
      run_ticks(10);
      // upper write-data bits beyond the register width are dropped
      configure(TICK_W'($urandom()), TICK_W'($urandom()), TICK_W'($urandom()),
                TICK_W'($urandom()), TICK_W'($urandom()),
                TICK_W'($urandom_range(65536, TICK_MAX)),
                TICK_W'($urandom()), TICK_W'($urandom()));
      run_ticks(20);

      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (ledger.errors == 0) begin
         $display("sprite_sheet_frame_sequencer verification clean");
      end else begin
         $display("sprite_sheet_frame_sequencer verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ssfs_pkg.sv
rtl/sprite_sheet_frame_sequencer.sv
rtl/ssfs_checker.sv
dv/tb_sprite_sheet_frame_sequencer.sv
